// ----- rtl/aee3_pkg.sv -----
`default_nettype none
package aee3_pkg;

	localparam int CNT_IN_W    = 16;
	localparam int IN_TDATA_W  = 48;
	localparam int PEND_W      = 32;
	localparam int OUT_FIELD_W = 34;
	localparam int OUT_TDATA_W = 40;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [PEND_W-1:0] PEND_MAX = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_DIV_LO,
		ST_MUL_HI,
		ST_DIV_HI,
		ST_CHECK,
		ST_RENORM,
		ST_FLUSH,
		ST_ERROR
	} aee3_state_t;

endpackage
`default_nettype wire

// ----- rtl/arithmetic_encoder_e3_top.sv -----
// Encode: a COUNT_BITS-bit shift-add multiply and a (PRECISION+COUNT_BITS+1)-bit restoring
// divide for the low bound, then the same for the high bound, a check, the renormalization
// shifts (each may send a held result) and the last result, all run one after another.
// Finish: sends the PRECISION bits of the interval midpoint as a tag, one bit per result.
// One item at a time; a result waiting on m_axis_tready can stall the block until taken.
// arst_n clears the interval to [0, 2^PRECISION-1], the pending count and the output valid.
`default_nettype none
module arithmetic_encoder_e3_top #(
	parameter int PRECISION  = 28,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output      logic                             s_axis_tready,
	// cum_low, cum_high, total_count
	input  wire logic [aee3_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// opcode
	input  wire logic                             s_axis_tuser,
	output      logic                             m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// code_bit, follow_count, error, zero pad
	output      logic [aee3_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// has_bit
	output      logic                             m_axis_tuser,
	output      logic                             m_axis_tlast
);
	import aee3_pkg::*;

	localparam int P  = PRECISION;
	localparam int C  = COUNT_BITS;
	localparam int W  = PRECISION + 1 + COUNT_BITS;
	localparam int CW = $clog2(W + 1);

	aee3_state_t state_q, state_d;

	logic [P-1:0]      low_q, high_q;
	logic [PEND_W-1:0] pend_q;
	logic              ov_q;

	logic [P:0]        len_q;
	logic [C-1:0]      ch_q, tot_q, mulop_q, rem_q;
	logic [W-1:0]      work_q, linc_q;
	logic [CW-1:0]     cnt_q;
	logic [P-1:0]      tag_q;
	logic              hold_v_q, hold_bit_q, err_acc_q;
	logic [PEND_W-1:0] hold_follow_q;

	logic              o_has_q, o_bit_q, o_err_q, o_last_q;
	logic [PEND_W-1:0] o_follow_q;

	logic [C-1:0] cl_in, ch_in, tot_in;

	generate
		if (C <= CNT_IN_W) begin : g_cnt_narrow
			assign cl_in  = s_axis_tdata[C-1:0];
			assign ch_in  = s_axis_tdata[CNT_IN_W+C-1:CNT_IN_W];
			assign tot_in = s_axis_tdata[2*CNT_IN_W+C-1:2*CNT_IN_W];
		end else begin : g_cnt_wide
			assign cl_in  = {{(C-CNT_IN_W){1'b0}}, s_axis_tdata[CNT_IN_W-1:0]};
			assign ch_in  = {{(C-CNT_IN_W){1'b0}}, s_axis_tdata[2*CNT_IN_W-1:CNT_IN_W]};
			assign tot_in = {{(C-CNT_IN_W){1'b0}}, s_axis_tdata[3*CNT_IN_W-1:2*CNT_IN_W]};
		end
	endgenerate

	logic          in_acc, ofree;
	logic          mul_last, div_last;
	logic [W-1:0]  mul_next;
	logic [C:0]    r_sh;
	logic          div_ge;
	logic [W-1:0]  div_next;
	logic [C-1:0]  rem_next;
	logic [W:0]    nl, nh, nhm1;
	logic          collapse;
	logic          uh, lh, u2, l2, e12, e3, rn_done, rn_step;
	logic [P:0]    tag_sum;

	logic              push, p_has, p_bit, p_err, p_last;
	logic [PEND_W-1:0] p_follow;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign ofree         = !ov_q || m_axis_tready;

	assign mul_last = (cnt_q == CW'(C - 1));
	assign div_last = (cnt_q == CW'(W - 1));
	assign mul_next = {work_q[W-2:0], 1'b0} + (mulop_q[C-1] ? W'(len_q) : W'(0));

	assign r_sh     = {rem_q, work_q[W-1]};
	assign div_ge   = (r_sh >= {1'b0, tot_q});
	assign rem_next = div_ge ? C'(r_sh - {1'b0, tot_q}) : r_sh[C-1:0];
	assign div_next = {work_q[W-2:0], div_ge};

	assign nl       = (W+1)'(low_q) + (W+1)'(linc_q);
	assign nh       = (W+1)'(low_q) + (W+1)'(work_q);
	assign nhm1     = nh - (W+1)'(1);
	assign collapse = (work_q == '0) || (nhm1 > (W+1)'(high_q)) || (nhm1 <= nl);

	assign uh      = high_q[P-1];
	assign lh      = low_q[P-1];
	assign u2      = high_q[P-2];
	assign l2      = low_q[P-2];
	assign e12     = (uh == lh);
	assign e3      = !e12 && !u2 && l2;
	assign rn_done = (cnt_q == CW'(P)) || (!e12 && !e3);
	assign rn_step = !rn_done && (e3 || !hold_v_q || ofree);

	assign tag_sum = {1'b0, low_q} + {1'b0, high_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
			low_q   <= '0;
			high_q  <= '1;
			pend_q  <= '0;
		end else begin
			state_q <= state_d;
			if (push) begin
				ov_q <= 1'b1;
			end else if (m_axis_tready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_CHECK: begin
					if (!collapse) begin
						high_q <= nhm1[P-1:0];
						low_q  <= nl[P-1:0];
					end
				end
				ST_RENORM: begin
					if (rn_step) begin
						if (e12) begin
							low_q  <= {low_q[P-2:0], 1'b0};
							high_q <= {high_q[P-2:0], 1'b1};
							pend_q <= '0;
						end else begin
							low_q  <= {~low_q[P-2], low_q[P-3:0], 1'b0};
							high_q <= {~high_q[P-2], high_q[P-3:0], 1'b1};
							if (pend_q != PEND_MAX) begin
								pend_q <= pend_q + PEND_W'(1);
							end
						end
					end
				end
				ST_FLUSH: begin
					if (ofree) begin
						pend_q <= '0;
						if (cnt_q == CW'(P - 1)) begin
							low_q  <= '0;
							high_q <= '1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			o_has_q    <= p_has;
			o_bit_q    <= p_bit;
			o_follow_q <= p_follow;
			o_err_q    <= p_err;
			o_last_q   <= p_last;
		end
		case (state_q)
			ST_IDLE: begin
				len_q   <= {1'b0, high_q} - {1'b0, low_q} + (P+1)'(1);
				ch_q    <= ch_in;
				tot_q   <= tot_in;
				mulop_q <= cl_in;
				work_q  <= '0;
				cnt_q   <= '0;
				tag_q   <= tag_sum[P:1];
			end
			ST_MUL_LO, ST_MUL_HI: begin
				work_q  <= mul_next;
				mulop_q <= {mulop_q[C-2:0], 1'b0};
				cnt_q   <= mul_last ? '0 : cnt_q + CW'(1);
				rem_q   <= '0;
			end
			ST_DIV_LO, ST_DIV_HI: begin
				rem_q <= rem_next;
				cnt_q <= div_last ? '0 : cnt_q + CW'(1);
				if (div_last && state_q == ST_DIV_LO) begin
					linc_q  <= div_next;
					work_q  <= '0;
					mulop_q <= ch_q;
				end else begin
					work_q <= div_next;
				end
			end
			ST_CHECK: begin
				cnt_q     <= '0;
				hold_v_q  <= 1'b0;
				err_acc_q <= 1'b0;
			end
			ST_RENORM: begin
				if (rn_step) begin
					cnt_q <= cnt_q + CW'(1);
					if (e12) begin
						hold_v_q      <= 1'b1;
						hold_bit_q    <= uh;
						hold_follow_q <= pend_q;
					end else if (pend_q == PEND_MAX) begin
						err_acc_q <= 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				if (ofree) begin
					cnt_q <= cnt_q + CW'(1);
					tag_q <= {tag_q[P-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		push     = 1'b0;
		p_has    = 1'b0;
		p_bit    = 1'b0;
		p_follow = '0;
		p_err    = 1'b0;
		p_last   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (s_axis_tuser == OP_FINISH) begin
						state_d = ST_FLUSH;
					end else if (tot_in == '0) begin
						state_d = ST_ERROR;
					end else begin
						state_d = ST_MUL_LO;
					end
				end
			end
			ST_MUL_LO: begin
				if (mul_last) begin
					state_d = ST_DIV_LO;
				end
			end
			ST_DIV_LO: begin
				if (div_last) begin
					state_d = ST_MUL_HI;
				end
			end
			ST_MUL_HI: begin
				if (mul_last) begin
					state_d = ST_DIV_HI;
				end
			end
			ST_DIV_HI: begin
				if (div_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = collapse ? ST_ERROR : ST_RENORM;
			end
			ST_RENORM: begin
				if (rn_done) begin
					if (ofree) begin
						push     = 1'b1;
						p_has    = hold_v_q;
						p_bit    = hold_v_q && hold_bit_q;
						p_follow = hold_v_q ? hold_follow_q : '0;
						p_err    = err_acc_q;
						p_last   = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (e12 && hold_v_q && ofree) begin
					push     = 1'b1;
					p_has    = 1'b1;
					p_bit    = hold_bit_q;
					p_follow = hold_follow_q;
				end
			end
			ST_FLUSH: begin
				if (ofree) begin
					push     = 1'b1;
					p_has    = 1'b1;
					p_bit    = tag_q[P-1];
					p_follow = pend_q;
					p_last   = (cnt_q == CW'(P - 1));
					if (p_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERROR: begin
				if (ofree) begin
					push    = 1'b1;
					p_err   = 1'b1;
					p_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tuser  = o_has_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, o_err_q, o_follow_q, o_bit_q};

endmodule
`default_nettype wire
